FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the min-heap priority queue modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	typedef logic signed [31:0] key_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_DN_LAST,
		S_DN_MOV,
		S_DN_LEFT,
		S_DN_RIGHT,
		S_DN_DEC,
		S_PUT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic cmd;
		key_t key;
	} req_t;

	typedef struct packed {
		status_t status;
		key_t    key;
	} rsp_t;

endpackage

FILE: design/mhpq_less.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_less
// Shared signed key comparator: lt is high when a is strictly below b.
// ----------------------------------------------------------------------------
module mhpq_less (
	input  mhpq_pkg::key_t a,
	input  mhpq_pkg::key_t b,
	output logic           lt
);

	assign lt = (a < b);

endmodule

FILE: design/mhpq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_core
// Heap sequencer: key store, entry count and sift-up / sift-down walk.
// ----------------------------------------------------------------------------
module mhpq_core #(
	parameter  int DEPTH = 16,
	localparam int AW    = $clog2(DEPTH),
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mhpq_pkg::req_t   req,
	input  logic [CW-1:0]    lim,
	output logic             idle,
	output logic             fin,
	input  logic             fin_ack,
	output mhpq_pkg::rsp_t   rsp,
	output logic [CW-1:0]    cnt
);

	mhpq_pkg::state_t  state_q, state_n;
	logic [CW-1:0]     cnt_q, cnt_n;
	logic [AW-1:0]     pos_q, pos_n;
	logic [AW-1:0]     cidx_q, cidx_n;
	mhpq_pkg::key_t    mov_q, mov_n;
	mhpq_pkg::key_t    cand_q, cand_n;
	mhpq_pkg::key_t    res_q, res_n;
	mhpq_pkg::status_t st_q, st_n;

	mhpq_pkg::key_t    mem [DEPTH];
	mhpq_pkg::key_t    rd_q;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	mhpq_pkg::key_t    wdata;

	mhpq_pkg::key_t    cmp_a, cmp_b;
	logic              lt;

	logic [AW-1:0]     cnt_par, pos_par, pp_par;
	logic [AW+1:0]     pos_left, pos_right, cid_left, n_ext;

	mhpq_less u_less (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt)
	);

	// index arithmetic
	assign cnt_par   = (AW'(cnt_q) - AW'(1)) >> 1;
	assign pos_par   = (pos_q - AW'(1)) >> 1;
	assign pp_par    = (pos_par - AW'(1)) >> 1;
	assign pos_left  = {1'b0, pos_q, 1'b1};
	assign pos_right = pos_left + (AW+2)'(1);
	assign cid_left  = {1'b0, cidx_q, 1'b1};
	assign n_ext     = (AW+2)'(cnt_q);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhpq_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_n;
		cidx_q <= cidx_n;
		mov_q  <= mov_n;
		cand_q <= cand_n;
		res_q  <= res_n;
		st_q   <= st_n;
	end

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		pos_n   = pos_q;
		cidx_n  = cidx_q;
		mov_n   = mov_q;
		cand_n  = cand_q;
		res_n   = res_q;
		st_n    = st_q;
		raddr   = '0;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = mov_q;
		cmp_a   = mov_q;
		cmp_b   = rd_q;
		idle    = 1'b0;
		fin     = 1'b0;
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					res_n = '0;
					case (req.cmd)
						mhpq_pkg::CMD_INSERT: begin
							if (cnt_q < lim) begin
								st_n  = mhpq_pkg::ST_DONE;
								mov_n = req.key;
								pos_n = AW'(cnt_q);
								cnt_n = cnt_q + CW'(1);
								if (cnt_q == '0) begin
									state_n = mhpq_pkg::S_PUT;
								end else begin
									raddr   = cnt_par;
									state_n = mhpq_pkg::S_UP;
								end
							end else begin
								st_n    = mhpq_pkg::ST_FULL;
								state_n = mhpq_pkg::S_FIN;
							end
						end
						mhpq_pkg::CMD_REMOVE: begin
							if (cnt_q == '0) begin
								st_n    = mhpq_pkg::ST_EMPTY;
								state_n = mhpq_pkg::S_FIN;
							end else begin
								st_n    = mhpq_pkg::ST_DONE;
								cnt_n   = cnt_q - CW'(1);
								raddr   = '0;
								state_n = mhpq_pkg::S_DN_LAST;
							end
						end
						default: state_n = mhpq_pkg::S_IDLE;
					endcase
				end
			end
			mhpq_pkg::S_UP: begin
				// rd_q holds the parent of pos_q
				cmp_a = mov_q;
				cmp_b = rd_q;
				if (lt) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = rd_q;
					pos_n = pos_par;
					if (pos_par == '0) begin
						state_n = mhpq_pkg::S_PUT;
					end else begin
						raddr = pp_par;
					end
				end else begin
					state_n = mhpq_pkg::S_PUT;
				end
			end
			mhpq_pkg::S_DN_LAST: begin
				res_n   = rd_q;
				raddr   = AW'(cnt_q);
				state_n = mhpq_pkg::S_DN_MOV;
			end
			mhpq_pkg::S_DN_MOV: begin
				mov_n = rd_q;
				pos_n = '0;
				if ((AW+2)'(1) < n_ext) begin
					raddr   = AW'(1);
					state_n = mhpq_pkg::S_DN_LEFT;
				end else begin
					state_n = mhpq_pkg::S_PUT;
				end
			end
			mhpq_pkg::S_DN_LEFT: begin
				cand_n = rd_q;
				cidx_n = pos_left[AW-1:0];
				if (pos_right < n_ext) begin
					raddr   = pos_right[AW-1:0];
					state_n = mhpq_pkg::S_DN_RIGHT;
				end else begin
					state_n = mhpq_pkg::S_DN_DEC;
				end
			end
			mhpq_pkg::S_DN_RIGHT: begin
				// equal children keep the left one
				cmp_a = rd_q;
				cmp_b = cand_q;
				if (lt) begin
					cand_n = rd_q;
					cidx_n = pos_right[AW-1:0];
				end
				state_n = mhpq_pkg::S_DN_DEC;
			end
			mhpq_pkg::S_DN_DEC: begin
				cmp_a = cand_q;
				cmp_b = mov_q;
				if (lt) begin
					we    = 1'b1;
					waddr = pos_q;
					wdata = cand_q;
					pos_n = cidx_q;
					if (cid_left < n_ext) begin
						raddr   = cid_left[AW-1:0];
						state_n = mhpq_pkg::S_DN_LEFT;
					end else begin
						state_n = mhpq_pkg::S_PUT;
					end
				end else begin
					state_n = mhpq_pkg::S_PUT;
				end
			end
			mhpq_pkg::S_PUT: begin
				we      = 1'b1;
				state_n = mhpq_pkg::S_FIN;
			end
			mhpq_pkg::S_FIN: begin
				fin = 1'b1;
				if (fin_ack) begin
					state_n = mhpq_pkg::S_IDLE;
				end
			end
			default: state_n = mhpq_pkg::S_IDLE;
		endcase
	end

	assign rsp.status = st_q;
	assign rsp.key    = res_q;
	assign cnt        = cnt_q;

endmodule

FILE: design/min_heap_priority_queue.sv
// Sequence: a refused insert or an empty remove goes straight to the result; an insert
//   into an empty heap writes the key at once, else climbs one level per parent compare;
//   remove reads root and last entry, then descends reading up to two children a level.
// Throughput: one request at a time, the next taken once idle after the result is loaded;
//   set by the key store and the shared comparator; a stalled result holds it.
// Reset: asynchronous, active low; heap empty, capacity_limit 16, no result pending.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of signed 32-bit keys with insert and remove-minimum.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic signed [31:0] key_in,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] key_out,
	output logic [4:0]         occupancy,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         capacity_limit
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(DEPTH + 1);
	// common width for comparing the 5-bit limit against DEPTH
	localparam int LW = (CW > 5) ? CW : 5;

	logic [4:0]        cap_q;
	logic [LW-1:0]     cap_w;
	logic [CW-1:0]     lim;

	logic              start;
	mhpq_pkg::req_t    req;
	logic              core_idle;
	logic              fin;
	logic              fin_ack;
	mhpq_pkg::rsp_t    rsp;
	logic [CW-1:0]     cnt;

	logic              out_valid_q;
	mhpq_pkg::status_t status_q;
	mhpq_pkg::key_t    key_q;
	logic [4:0]        occ_q;

	// configuration: taken at any time, only written while idle by contract
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= capacity_limit;
		end
	end

	// a limit above the store depth saturates at DEPTH
	assign cap_w = LW'(cap_q);
	assign lim   = (cap_w > LW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_w);

	// a request enters only while the sequencer sits idle; a finished
	// result may still be waiting in the output register
	assign in_ready = core_idle;
	assign start    = in_valid && in_ready;
	assign req.cmd  = command;
	assign req.key  = key_in;

	mhpq_core #(
		.DEPTH (DEPTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.lim     (lim),
		.idle    (core_idle),
		.fin     (fin),
		.fin_ack (fin_ack),
		.rsp     (rsp),
		.cnt     (cnt)
	);

	// output register: the sequencer hands over its result when the slot
	// is free or is being emptied in the same cycle
	assign fin_ack = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin && fin_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin && fin_ack) begin
			status_q <= rsp.status;
			key_q    <= rsp.key;
			occ_q    <= 5'(cnt);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign key_out   = key_q;
	assign occupancy = occ_q;

	// a taken request always sends the sequencer busy
	`ASSERT_NEXT(a_busy_after_req, start, !in_ready, "sequencer stayed idle after a request")
	// the entry count never passes the store depth
	`ASSERT_IMPL(a_cnt_bound, 1'b1, cnt <= CW'(DEPTH), "entry count above depth")
	// only a successful remove carries a key
	`ASSERT_IMPL(a_key_zero, out_valid && (status != mhpq_pkg::ST_DONE), key_out == '0,
		"nonzero key on a refused request")
	// a handed-over result shows up on the output
	`ASSERT_NEXT(a_result_loaded, fin && fin_ack, out_valid, "result lost at handover")

endmodule
